### sv/fodm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fodm_pkg;

    // Register map, by word index on the configuration port.
    localparam logic REG_DEADBAND = 1'b0;
    localparam logic REG_OFFSET   = 1'b1;

    // Values after reset.
    localparam logic [6:0] DEADBAND_RESET = 7'd21;
    localparam logic [8:0] OFFSET_RESET   = 9'd45;

    // Degrees in a full turn and in a quarter turn.
    localparam logic [9:0] DEG_FULL    = 10'd360;
    localparam logic [8:0] DEG_QUARTER = 9'd90;
    localparam int         TAB_LAST    = 90;

    // Pi in Q30, used to build the quarter-wave sine table.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [6:0] deadband;
        logic [8:0] offset;
    } t_cfg;

    // Quarter-wave table address and sign for one angle.
    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } t_quad;

    // Multiply a Q30 term by x twice, keeping Q30 after each product.
    function automatic longint unsigned sq_step(input longint unsigned term,
                                                input longint unsigned x);
        longint unsigned t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Sine of d degrees in Q1.frac, evaluated at elaboration time only.
    // A Q30 Taylor series with thirteen terms, then rounded half up.
    function automatic longint quarter_sin(input int d, input int frac);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        x = (PI_Q30 * 64'(d) + 64'd90) / 64'd180;
        sum = x;
        term = sq_step(x, x) / 64'd6;
        sum = sum - term;
        term = sq_step(term, x) / 64'd20;
        sum = sum + term;
        term = sq_step(term, x) / 64'd42;
        sum = sum - term;
        term = sq_step(term, x) / 64'd72;
        sum = sum + term;
        term = sq_step(term, x) / 64'd110;
        sum = sum - term;
        term = sq_step(term, x) / 64'd156;
        sum = sum + term;
        term = sq_step(term, x) / 64'd210;
        sum = sum - term;
        term = sq_step(term, x) / 64'd272;
        sum = sum + term;
        term = sq_step(term, x) / 64'd342;
        sum = sum - term;
        term = sq_step(term, x) / 64'd420;
        sum = sum + term;
        term = sq_step(term, x) / 64'd506;
        sum = sum - term;
        term = sq_step(term, x) / 64'd600;
        sum = sum + term;
        return longint'((sum + (64'd1 << (29 - frac))) >> (30 - frac));
    endfunction

    // Fold an angle in 0..359 onto the first quadrant of the sine table.
    function automatic t_quad quad_of(input logic [8:0] a);
        t_quad q;
        logic [8:0] v;
        q.neg = 1'b0;
        v = a;
        if (a <= DEG_QUARTER) begin
            v = a;
        end else if (a <= 9'd180) begin
            v = 9'd180 - a;
        end else if (a <= 9'd270) begin
            v = a - 9'd180;
            q.neg = 1'b1;
        end else begin
            v = 9'(DEG_FULL) - a;
            q.neg = 1'b1;
        end
        q.idx = v[6:0];
        return q;
    endfunction

endpackage

`default_nettype wire

### sv/field_oriented_omni_drive_mixer.sv
// Accepted items pass through five register stages, each with its own valid bit,
// to their wheel commands at the outputs; one item per cycle while not stalled.
// A stall at the output holds the pipeline, and empty stages still fill behind it.
// Reset (synchronous, active low) empties the pipeline and loads the deadband
// with 21 and the heading offset with 45.
`timescale 1ns / 1ps
`default_nettype none

module field_oriented_omni_drive_mixer #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic signed [7:0] i_spin_stick,
    input  wire logic signed [7:0] i_drive_x,
    input  wire logic signed [7:0] i_drive_y,
    input  wire logic [8:0]        i_robot_heading,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic signed [8:0]      o_front_right_cmd,
    output logic signed [8:0]      o_front_left_cmd,
    output logic signed [8:0]      o_back_left_cmd,
    output logic signed [8:0]      o_back_right_cmd
);

    fodm_pkg::t_cfg                   w_cfg;
    logic                             w_mid_valid;
    logic                             w_mid_stall;
    logic signed [7:0]                w_jx;
    logic signed [7:0]                w_jy;
    logic signed [TRIG_FRAC_BITS+1:0] w_sin;
    logic signed [TRIG_FRAC_BITS+1:0] w_cos;
    logic signed [6:0]                w_spin;

    // Configuration registers.
    fodm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Stick scaling, spin deadband and trig lookup.
    fodm_prep #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_spin_stick    (i_spin_stick),
        .i_drive_x       (i_drive_x),
        .i_drive_y       (i_drive_y),
        .i_robot_heading (i_robot_heading),
        .o_valid         (w_mid_valid),
        .i_stall         (w_mid_stall),
        .o_jx            (w_jx),
        .o_jy            (w_jy),
        .o_sin           (w_sin),
        .o_cos           (w_cos),
        .o_spin          (w_spin)
    );

    // Rotation and wheel mixing.
    fodm_rot #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rot (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_mid_valid),
        .o_stall           (w_mid_stall),
        .i_jx              (w_jx),
        .i_jy              (w_jy),
        .i_sin             (w_sin),
        .i_cos             (w_cos),
        .i_spin            (w_spin),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_front_right_cmd (o_front_right_cmd),
        .o_front_left_cmd  (o_front_left_cmd),
        .o_back_left_cmd   (o_back_left_cmd),
        .o_back_right_cmd  (o_back_right_cmd)
    );

endmodule

`default_nettype wire

### sv/fodm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module fodm_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fodm_pkg::t_cfg      o_cfg
);

    logic [6:0] r_deadband;
    logic [8:0] r_offset;
    logic       w_wr;
    logic       w_sel;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_sel  = paddr[2];

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= fodm_pkg::DEADBAND_RESET;
            r_offset   <= fodm_pkg::OFFSET_RESET;
        end else if (w_wr) begin
            case (w_sel)
                fodm_pkg::REG_DEADBAND: r_deadband <= pwdata[6:0];
                fodm_pkg::REG_OFFSET:   r_offset   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (w_sel)
            fodm_pkg::REG_DEADBAND: prdata = {25'd0, r_deadband};
            fodm_pkg::REG_OFFSET:   prdata = {23'd0, r_offset};
            default:                prdata = 32'd0;
        endcase
    end

    assign o_cfg = {r_deadband, r_offset};

endmodule

`default_nettype wire

### sv/fodm_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module fodm_prep #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fodm_pkg::t_cfg                i_cfg,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [7:0]             i_spin_stick,
    input  wire logic signed [7:0]             i_drive_x,
    input  wire logic signed [7:0]             i_drive_y,
    input  wire logic [8:0]                    i_robot_heading,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [7:0]                  o_jx,
    output logic signed [7:0]                  o_jy,
    output logic signed [TRIG_FRAC_BITS+1:0]   o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0]   o_cos,
    output logic signed [6:0]                  o_spin
);

    localparam int SW = TRIG_FRAC_BITS + 2;

    // Quarter-wave sine table, constant.
    logic signed [SW-1:0] w_tab [0:fodm_pkg::TAB_LAST];

    for (genvar gi = 0; gi <= fodm_pkg::TAB_LAST; gi++) begin : g_tab
        localparam logic signed [SW-1:0] TAB_VAL =
            SW'(fodm_pkg::quarter_sin(gi, TRIG_FRAC_BITS));
        assign w_tab[gi] = TAB_VAL;
    end

    logic w_en1;
    logic w_en2;
    logic r1_v;
    logic r2_v;

    // Stage advance: a stage moves when it is empty or its successor moves.
    assign w_en2   = !r2_v || !i_stall;
    assign w_en1   = !r1_v || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r2_v;

    // Stage 1: magnitudes, scale by 100, spin term and rotation angle.
    logic [7:0]        n_mx;
    logic [7:0]        n_my;
    logic [7:0]        n_ms;
    logic [15:0]       n_sp3;
    logic [5:0]        n_q3;
    logic signed [6:0] n_spin;
    logic [8:0]        n_hd;
    logic [8:0]        n_off;
    logic [9:0]        n_sum;
    logic [8:0]        n_t;
    logic [8:0]        n_ang;

    always_comb begin
        n_mx  = i_drive_x[7] ? 8'(-i_drive_x) : 8'(i_drive_x);
        n_my  = i_drive_y[7] ? 8'(-i_drive_y) : 8'(i_drive_y);
        n_ms  = i_spin_stick[7] ? 8'(-i_spin_stick) : 8'(i_spin_stick);
        // Divide by 3 as a multiply by 171/512, exact for magnitudes up to 128.
        n_sp3 = 16'(n_ms) * 16'd171;
        n_q3  = n_sp3[14:9];
        if (n_ms > {1'b0, i_cfg.deadband}) begin
            n_spin = i_spin_stick[7] ? -7'(n_q3) : 7'(n_q3);
        end else begin
            n_spin = 7'sd0;
        end
        n_hd  = (i_robot_heading >= 9'(fodm_pkg::DEG_FULL))
              ? i_robot_heading - 9'(fodm_pkg::DEG_FULL) : i_robot_heading;
        n_off = (i_cfg.offset >= 9'(fodm_pkg::DEG_FULL))
              ? i_cfg.offset - 9'(fodm_pkg::DEG_FULL) : i_cfg.offset;
        n_sum = 10'(n_hd) + 10'(n_off);
        n_t   = (n_sum >= fodm_pkg::DEG_FULL) ? 9'(n_sum - fodm_pkg::DEG_FULL) : n_sum[8:0];
        n_ang = (n_t == 9'd0) ? 9'd0 : 9'(fodm_pkg::DEG_FULL) - n_t;
    end

    logic [13:0]       r1_px;
    logic [13:0]       r1_py;
    logic              r1_xneg;
    logic              r1_yneg;
    logic signed [6:0] r1_spin;
    logic [8:0]        r1_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_px   <= 14'(n_mx) * 14'd100;
            r1_py   <= 14'(n_my) * 14'd100;
            r1_xneg <= i_drive_x[7];
            // The y axis is negated, so a negative stick gives a positive value.
            r1_yneg <= !i_drive_y[7];
            r1_spin <= n_spin;
            r1_ang  <= n_ang;
        end
    end

    // Stage 2: divide by 127 and look up sine and cosine.
    logic [21:0]          n_x129;
    logic [21:0]          n_y129;
    logic [6:0]           n_qx0;
    logic [6:0]           n_qy0;
    logic [13:0]          n_rx;
    logic [13:0]          n_ry;
    logic [6:0]           n_qx;
    logic [6:0]           n_qy;
    logic [9:0]           n_a90;
    logic [8:0]           n_ac;
    fodm_pkg::t_quad      n_qs;
    fodm_pkg::t_quad      n_qc;
    logic signed [SW-1:0] n_sv;
    logic signed [SW-1:0] n_cv;

    always_comb begin
        // 129/16384 is just under 1/127, so the estimate is low by at most one.
        n_x129 = 22'(r1_px) * 22'd129;
        n_y129 = 22'(r1_py) * 22'd129;
        n_qx0  = n_x129[20:14];
        n_qy0  = n_y129[20:14];
        n_rx   = r1_px - ((14'(n_qx0) << 7) - 14'(n_qx0));
        n_ry   = r1_py - ((14'(n_qy0) << 7) - 14'(n_qy0));
        n_qx   = (n_rx >= 14'd127) ? n_qx0 + 7'd1 : n_qx0;
        n_qy   = (n_ry >= 14'd127) ? n_qy0 + 7'd1 : n_qy0;
        // Cosine is the sine ninety degrees on.
        n_a90  = 10'(r1_ang) + 10'(fodm_pkg::DEG_QUARTER);
        n_ac   = (n_a90 >= fodm_pkg::DEG_FULL) ? 9'(n_a90 - fodm_pkg::DEG_FULL) : n_a90[8:0];
        n_qs   = fodm_pkg::quad_of(r1_ang);
        n_qc   = fodm_pkg::quad_of(n_ac);
        n_sv   = n_qs.neg ? -w_tab[n_qs.idx] : w_tab[n_qs.idx];
        n_cv   = n_qc.neg ? -w_tab[n_qc.idx] : w_tab[n_qc.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            o_jx   <= r1_xneg ? -8'(n_qx) : 8'(n_qx);
            o_jy   <= r1_yneg ? -8'(n_qy) : 8'(n_qy);
            o_sin  <= n_sv;
            o_cos  <= n_cv;
            o_spin <= r1_spin;
        end
    end

endmodule

`default_nettype wire

### sv/fodm_rot.sv
`timescale 1ns / 1ps
`default_nettype none

module fodm_rot #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [7:0]                  i_jx,
    input  wire logic signed [7:0]                  i_jy,
    input  wire logic signed [TRIG_FRAC_BITS+1:0]   i_sin,
    input  wire logic signed [TRIG_FRAC_BITS+1:0]   i_cos,
    input  wire logic signed [6:0]                  i_spin,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [8:0]                       o_front_right_cmd,
    output logic signed [8:0]                       o_front_left_cmd,
    output logic signed [8:0]                       o_back_left_cmd,
    output logic signed [8:0]                       o_back_right_cmd
);

    localparam int PW = TRIG_FRAC_BITS + 10;
    localparam int SUMW = PW + 1;
    localparam logic signed [SUMW-1:0] RND =
        SUMW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    logic w_en3;
    logic w_en4;
    logic w_en5;
    logic r3_v;
    logic r4_v;
    logic r5_v;

    // Stage advance: a stage moves when it is empty or its successor moves.
    assign w_en5   = !r5_v || !i_stall;
    assign w_en4   = !r4_v || w_en5;
    assign w_en3   = !r3_v || w_en4;
    assign o_stall = !w_en3;
    assign o_valid = r5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (w_en3) begin
                r3_v <= i_valid;
            end
            if (w_en4) begin
                r4_v <= r3_v;
            end
            if (w_en5) begin
                r5_v <= r4_v;
            end
        end
    end

    // Stage 3: the four rotation products.
    logic signed [PW-1:0] r3_xc;
    logic signed [PW-1:0] r3_ys;
    logic signed [PW-1:0] r3_xs;
    logic signed [PW-1:0] r3_yc;
    logic signed [6:0]    r3_spin;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_xc   <= PW'(i_jx) * PW'(i_cos);
            r3_ys   <= PW'(i_jy) * PW'(i_sin);
            r3_xs   <= PW'(i_jx) * PW'(i_sin);
            r3_yc   <= PW'(i_jy) * PW'(i_cos);
            r3_spin <= i_spin;
        end
    end

    // Stage 4: full-precision sums of the rotated vector.
    logic signed [SUMW-1:0] r4_rxs;
    logic signed [SUMW-1:0] r4_rys;
    logic signed [6:0]      r4_spin;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_rxs  <= SUMW'(r3_xc) - SUMW'(r3_ys);
            r4_rys  <= SUMW'(r3_xs) + SUMW'(r3_yc);
            r4_spin <= r3_spin;
        end
    end

    // Stage 5: truncate toward zero and mix in the spin term.
    logic signed [SUMW-1:0] n_rxb;
    logic signed [SUMW-1:0] n_ryb;
    logic signed [SUMW-1:0] n_rxq;
    logic signed [SUMW-1:0] n_ryq;
    logic signed [9:0]      n_rx;
    logic signed [9:0]      n_ry;
    logic signed [9:0]      n_sp;
    logic signed [9:0]      n_fr;
    logic signed [9:0]      n_fl;
    logic signed [9:0]      n_bl;
    logic signed [9:0]      n_br;

    always_comb begin
        n_rxb = r4_rxs + (r4_rxs[SUMW-1] ? RND : SUMW'(0));
        n_ryb = r4_rys + (r4_rys[SUMW-1] ? RND : SUMW'(0));
        n_rxq = n_rxb >>> TRIG_FRAC_BITS;
        n_ryq = n_ryb >>> TRIG_FRAC_BITS;
        n_rx  = n_rxq[9:0];
        n_ry  = n_ryq[9:0];
        n_sp  = 10'(r4_spin);
        n_fr  = -n_rx - n_sp;
        n_fl  = n_ry - n_sp;
        n_bl  = -n_rx + n_sp;
        n_br  = n_ry + n_sp;
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            o_front_right_cmd <= n_fr[8:0];
            o_front_left_cmd  <= n_fl[8:0];
            o_back_left_cmd   <= n_bl[8:0];
            o_back_right_cmd  <= n_br[8:0];
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 14;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam longint unsigned PI_SCALED = 64'd3373259426;

    // One stick sample and the four wheel commands it produces.
    typedef struct {
        logic signed [7:0] spin;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [8:0]        heading;
    } t_stick_sample;

    typedef struct {
        logic signed [8:0] fr;
        logic signed [8:0] fl;
        logic signed [8:0] bl;
        logic signed [8:0] br;
    } t_wheel_cmds;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic signed [7:0] i_spin_stick = '0;
    logic signed [7:0] i_drive_x = '0;
    logic signed [7:0] i_drive_y = '0;
    logic [8:0]        i_robot_heading = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic signed [8:0] o_front_right_cmd;
    logic signed [8:0] o_front_left_cmd;
    logic signed [8:0] o_back_left_cmd;
    logic signed [8:0] o_back_right_cmd;

    field_oriented_omni_drive_mixer #(
        .TRIG_FRAC_BITS(FRAC)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_spin_stick(i_spin_stick),
        .i_drive_x(i_drive_x),
        .i_drive_y(i_drive_y),
        .i_robot_heading(i_robot_heading),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_front_right_cmd(o_front_right_cmd),
        .o_front_left_cmd(o_front_left_cmd),
        .o_back_left_cmd(o_back_left_cmd),
        .o_back_right_cmd(o_back_right_cmd)
    );

    // Testbench state: pending samples, predicted commands and the
    // configuration the block should currently hold.
    t_stick_sample sample_q[$];
    t_wheel_cmds   wheel_q[$];
    longint        sine_q[0:90];
    logic [6:0]    cfg_deadband = fodm_pkg::DEADBAND_RESET;
    logic [8:0]    cfg_offset = fodm_pkg::OFFSET_RESET;
    int            err_count = 0;
    int            quiet_cycles = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    bit            idling = 1'b1;
    bit            in_took = 1'b0;
    t_stick_sample drv_smp;
    t_wheel_cmds   got_cmds;
    t_wheel_cmds   want_cmds;
    t_stick_sample seen_smp;

    // Clock.
    always #5 i_clk = ~i_clk;

    // Quarter-wave sine table in Q1.FRAC, from a Q30 Taylor series.
    task automatic build_sine_table();
        longint unsigned x;
        longint unsigned term;
        longint unsigned sum;
        int d;
        int n;
        for (d = 0; d <= 90; d++) begin
            x = (PI_SCALED * longint'(d) + 64'd90) / 64'd180;
            term = x;
            sum = x;
            for (n = 1; n <= 12; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            sine_q[d] = longint'((sum + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
        end
    endtask

    // Sine of a whole-degree angle, folded onto the quarter table.
    function automatic longint sine_deg(input int a);
        int r;
        r = a % 360;
        if (r <= 90) begin
            return sine_q[r];
        end else if (r <= 180) begin
            return sine_q[180 - r];
        end else if (r <= 270) begin
            return -sine_q[r - 180];
        end
        return -sine_q[360 - r];
    endfunction

    // Field-oriented mix: deadbanded spin, scaled and rotated translation.
    function automatic t_wheel_cmds mix_wheels(input t_stick_sample smp);
        t_wheel_cmds w;
        int sp;
        int mag;
        int t;
        int a;
        longint spin;
        longint jx;
        longint jy;
        longint s;
        longint c;
        longint rx;
        longint ry;
        longint one;
        sp = smp.spin;
        mag = (sp < 0) ? -sp : sp;
        spin = (mag > int'(cfg_deadband)) ? longint'(sp / 3) : 0;
        jx = (int'(smp.dx) * 100) / 127;
        jy = -((int'(smp.dy) * 100) / 127);
        t = (int'(smp.heading) % 360 + int'(cfg_offset) % 360) % 360;
        a = (360 - t) % 360;
        s = sine_deg(a);
        c = sine_deg(a + 90);
        one = longint'(1) << FRAC;
        rx = (jx * c - jy * s) / one;
        ry = (jx * s + jy * c) / one;
        w.fr = 9'(-rx - spin);
        w.fl = 9'(ry - spin);
        w.bl = 9'(-rx + spin);
        w.br = 9'(ry + spin);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Driver: presents the next sample once the current one is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_took)) begin
            if (idling && send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap = send_gap - 1;
            end else if (sample_q.size() != 0) begin
                drv_smp = sample_q.pop_front();
                i_spin_stick <= drv_smp.spin;
                i_drive_x <= drv_smp.dx;
                i_drive_y <= drv_smp.dy;
                i_robot_heading <= drv_smp.heading;
                i_valid <= 1'b1;
                if (idling && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 19);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (idling && stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if (idling && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
        end
    end

    // Monitor: checks each taken result, then predicts each taken item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got_cmds.fr = o_front_right_cmd;
                got_cmds.fl = o_front_left_cmd;
                got_cmds.bl = o_back_left_cmd;
                got_cmds.br = o_back_right_cmd;
                if (wheel_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 1, 0);
                end else begin
                    want_cmds = wheel_q.pop_front();
                    if (got_cmds.fr !== want_cmds.fr)
                        report_mismatch("front_right_cmd", got_cmds.fr, want_cmds.fr);
                    if (got_cmds.fl !== want_cmds.fl)
                        report_mismatch("front_left_cmd", got_cmds.fl, want_cmds.fl);
                    if (got_cmds.bl !== want_cmds.bl)
                        report_mismatch("back_left_cmd", got_cmds.bl, want_cmds.bl);
                    if (got_cmds.br !== want_cmds.br)
                        report_mismatch("back_right_cmd", got_cmds.br, want_cmds.br);
                end
            end
            if (i_valid && !o_stall) begin
                seen_smp.spin = i_spin_stick;
                seen_smp.dx = i_drive_x;
                seen_smp.dy = i_drive_y;
                seen_smp.heading = i_robot_heading;
                wheel_q.push_back(mix_wheels(seen_smp));
            end
        end
        in_took <= i_rst_n && i_valid && !o_stall;
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == fodm_pkg::REG_DEADBAND) begin
            cfg_deadband = val[6:0];
        end else begin
            cfg_offset = val[8:0];
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_sample(input int sp, input int dx, input int dy, input int hd);
        t_stick_sample smp;
        smp.spin = 8'(sp);
        smp.dx = 8'(dx);
        smp.dy = 8'(dy);
        smp.heading = 9'(hd);
        sample_q.push_back(smp);
    endtask

    // Random sample; a quarter of spins sit at the deadband edge.
    function automatic t_stick_sample random_sample();
        t_stick_sample smp;
        int k;
        smp.spin = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            k = int'(cfg_deadband) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) k = -k;
            smp.spin = 8'(k);
        end
        smp.dx = 8'($urandom);
        smp.dy = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            smp.heading = 9'($urandom_range(360, 511));
        end else begin
            smp.heading = 9'($urandom_range(0, 359));
        end
        return smp;
    endfunction

    // Wait until every item is taken and every result has come back.
    task automatic drain();
        @(posedge i_clk);
        while (sample_q.size() != 0 || i_valid || wheel_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            sample_q.push_back(random_sample());
        end
        drain();
    endtask

    initial begin
        build_sine_table();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset configuration.
        push_sample(0, 0, 0, 0);
        push_sample(127, 127, 127, 0);
        push_sample(-128, -128, -128, 0);
        push_sample(-128, 127, -128, 359);
        push_sample(127, -128, 127, 359);
        push_sample(21, 100, -50, 90);
        push_sample(-21, -100, 50, 180);
        push_sample(22, 64, 64, 270);
        push_sample(-22, -64, 64, 45);
        push_sample(20, 127, 0, 315);
        push_sample(-23, 0, 127, 135);
        push_sample(1, 1, 1, 1);
        push_sample(-1, -1, -1, 300);
        push_sample(64, -128, 127, 360);
        push_sample(-64, 127, -128, 511);
        push_sample(100, 90, -90, 450);
        push_sample(-128, 0, 0, 225);
        push_sample(127, 0, -128, 405);
        push_sample(3, -127, -127, 269);
        push_sample(-3, 127, 127, 91);
        drain();

        // Lowest settings.
        write_reg(fodm_pkg::REG_DEADBAND, 32'd0);
        write_reg(fodm_pkg::REG_OFFSET, 32'd0);
        run_random(300);

        // Highest in-range settings.
        write_reg(fodm_pkg::REG_DEADBAND, {25'($urandom), 7'd127});
        write_reg(fodm_pkg::REG_OFFSET, 32'd359);
        run_random(300);

        // Offset past a full turn, wrapping.
        write_reg(fodm_pkg::REG_DEADBAND, 32'($urandom_range(0, 127)));
        write_reg(fodm_pkg::REG_OFFSET, {23'($urandom), 9'($urandom_range(360, 511))});
        run_random(300);

        write_reg(fodm_pkg::REG_DEADBAND, 32'($urandom_range(0, 127)));
        write_reg(fodm_pkg::REG_OFFSET, 32'($urandom_range(0, 359)));
        run_random(300);

        // Last stretch at full rate with no idling.
        write_reg(fodm_pkg::REG_OFFSET, 32'd511);
        write_reg(fodm_pkg::REG_DEADBAND, 32'd21);
        idling = 1'b0;
        run_random(330);

        repeat (20) @(posedge i_clk);
        if (wheel_q.size() != 0) begin
            report_mismatch("results never arrived", 0, wheel_q.size());
        end
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
sv/fodm_pkg.sv
sv/fodm_cfg.sv
sv/fodm_prep.sv
sv/fodm_rot.sv
sv/field_oriented_omni_drive_mixer.sv
tb/sv/tb.sv
